// File: rtl/pdat_pkg.sv
// pdat_pkg: shared widths, register indexes and constants for the altitude throttle block
// used by pdat_mul and pd_altitude_throttle_top; no dependencies

package pdat_pkg;

    // field widths
    localparam int ALT_W    = 10;
    localparam int GAIN_W   = 16;
    localparam int THR_W    = 10;
    localparam int PULSE_W  = 11;
    localparam int ERR_W    = 11;
    localparam int DIFF_W   = 12;
    localparam int CFG_W    = 16;
    localparam int CFG_IDX_W = 3;

    // shared multiplier operand and product widths
    localparam int MUL_A_W  = 17;
    localparam int MUL_B_W  = 22;
    localparam int MUL_P_W  = MUL_A_W + MUL_B_W;

    // signed q22.8 accumulator (30 bits, 8 fraction bits)
    localparam int ACC_W    = 30;
    localparam int FRAC_W   = 8;

    // pulse mapping: divide by 999 via reciprocal, 2^24 / 999 rounded down
    localparam int THR_MAX    = 999;
    localparam int RECIP_SH   = 24;
    localparam int RECIP      = (1 << RECIP_SH) / THR_MAX;
    localparam int PROD_W     = 21;
    localparam int QUOT_W     = 11;
    localparam int PSUM_W     = 12;

    // default pulse range in microseconds
    localparam int MIN_PULSE_DEF = 1000;
    localparam int MAX_PULSE_DEF = 2000;

    // configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_TARGET       = 3'd0,
        CFG_PROP_GAIN    = 3'd1,
        CFG_DERIV_GAIN   = 3'd2,
        CFG_BASE_CLOSED  = 3'd3,
        CFG_LIMIT_CLOSED = 3'd4,
        CFG_BASE_OPEN    = 3'd5,
        CFG_LIMIT_OPEN   = 3'd6
    } cfg_index_t;

    // operands for the shared multiplier
    typedef struct packed {
        logic                      en;
        logic signed [MUL_A_W-1:0] a;
        logic signed [MUL_B_W-1:0] b;
    } mul_req_t;

endpackage

// File: rtl/pdat_mul.sv
// pdat_mul: shared signed multiplier with a registered product
// depends on pdat_pkg for operand widths and the request struct

module pdat_mul (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  pdat_pkg::mul_req_t                    req,
    output logic signed [pdat_pkg::MUL_P_W-1:0]   product
);
    import pdat_pkg::*;

    logic signed [MUL_P_W-1:0] product_reg;

    // one multiply per cycle, held when idle
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            product_reg <= '0;
        end
        else if (req.en)
        begin
            product_reg <= req.a * req.b;
        end
    end

    assign product = product_reg;

endmodule

// File: rtl/pd_altitude_throttle_top.sv
// pd_altitude_throttle_top: pd altitude hold with clamped throttle and servo pulse mapping
// depends on pdat_pkg and pdat_mul
//
//  channel   | direction | payload (lowest bit first)
//  s_axis    | in        | tdata: altitude_cm[9:0], zero pad; tuser: grabber_open
//  m_axis    | out       | tdata: throttle_level[9:0], pulse_us[20:10], zero pad
//  cfg       | in        | cfg_index selects register, cfg_data holds the value
//
// an item steps through the states from prop to fix, then done loads the result and returns
// to idle, where the input is ready again; every product goes through the one registered
// 17x22 multiplier (two for the correction, three for the pulse mapping), one per cycle.
// s_axis_tready is high only while the sequencer is idle; a finished result waits in the
// output register, so the next item is taken while m_axis stalls.
// reset clears the registers to their defaults and the previous error to zero.

module pd_altitude_throttle_top #(
    parameter int MIN_PULSE = pdat_pkg::MIN_PULSE_DEF,
    parameter int MAX_PULSE = pdat_pkg::MAX_PULSE_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    input  logic [15:0]                         s_axis_tdata,   // altitude_cm[9:0], pad
    input  logic [0:0]                          s_axis_tuser,   // grabber_open
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    output logic [23:0]                         m_axis_tdata,   // throttle_level, pulse_us, pad
    input  logic                                cfg_wr_en,
    input  logic [pdat_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [pdat_pkg::CFG_W-1:0]          cfg_data
);
    import pdat_pkg::*;

    localparam logic signed [MUL_A_W-1:0] SPAN_OP  = MUL_A_W'(MAX_PULSE - MIN_PULSE);
    localparam logic signed [MUL_A_W-1:0] RECIP_OP = MUL_A_W'(RECIP);
    localparam logic signed [MUL_A_W-1:0] DIV_OP   = MUL_A_W'(THR_MAX);
    localparam logic [PSUM_W-1:0]         MIN_OP   = PSUM_W'(MIN_PULSE);
    localparam logic [THR_W-1:0]          THR_TOP  = THR_W'(THR_MAX);

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_PROP,
        ST_DERIV,
        ST_SUM,
        ST_CLAMP,
        ST_SPAN,
        ST_RECIP,
        ST_QMUL,
        ST_FIX,
        ST_DONE
    } state_t;

    state_t                      state_reg;

    // configuration registers
    logic [ALT_W-1:0]            target_reg;
    logic [GAIN_W-1:0]           kp_reg;
    logic [GAIN_W-1:0]           kd_reg;
    logic [THR_W-1:0]            base_closed_reg;
    logic [THR_W-1:0]            limit_closed_reg;
    logic [THR_W-1:0]            base_open_reg;
    logic [THR_W-1:0]            limit_open_reg;

    // datapath registers
    logic signed [ERR_W-1:0]     prev_err_reg;
    logic signed [ERR_W-1:0]     err_reg;
    logic signed [DIFF_W-1:0]    diff_reg;
    logic                        open_reg;
    logic signed [ACC_W-1:0]     acc_reg;
    logic [THR_W-1:0]            thr_reg;
    logic [PROD_W-1:0]           p_reg;
    logic [QUOT_W-1:0]           q_reg;

    // output register
    logic                        m_valid_reg;
    logic [THR_W-1:0]            out_thr_reg;
    logic [PULSE_W-1:0]          out_pulse_reg;

    logic                        s_xfer;
    logic signed [ERR_W-1:0]     err_now;
    logic signed [DIFF_W-1:0]    diff_now;
    logic [THR_W-1:0]            base_sel;
    logic [THR_W-1:0]            limit_raw;
    logic [THR_W-1:0]            limit_sel;
    logic [PROD_W-1:0]           thr_pos;
    logic [THR_W-1:0]            thr_next;
    logic [QUOT_W-1:0]           q_est;
    logic [PROD_W:0]             rem;
    logic [PSUM_W-1:0]           pulse_sum;
    mul_req_t                    mul_req;
    logic signed [MUL_P_W-1:0]   mul_q;

    assign s_xfer = s_axis_tvalid && s_axis_tready;

    // error and its change against the last reading
    assign err_now  = $signed({1'b0, target_reg}) - $signed({1'b0, s_axis_tdata[ALT_W-1:0]});
    assign diff_now = DIFF_W'(err_now) - DIFF_W'(prev_err_reg);

    // base and limit for the grabber position, limit held to 999
    assign base_sel  = open_reg ? base_open_reg : base_closed_reg;
    assign limit_raw = open_reg ? limit_open_reg : limit_closed_reg;
    assign limit_sel = (limit_raw > THR_TOP) ? THR_TOP : limit_raw;

    // truncate toward zero and clamp; any negative sum ends at zero
    assign thr_pos = acc_reg[FRAC_W +: PROD_W];
    always_comb
    begin
        if (acc_reg[ACC_W-1])
        begin
            thr_next = '0;
        end
        else if (thr_pos > PROD_W'(limit_sel))
        begin
            thr_next = limit_sel;
        end
        else
        begin
            thr_next = thr_pos[THR_W-1:0];
        end
    end

    // reciprocal quotient estimate and remainder check
    assign q_est     = mul_q[RECIP_SH +: QUOT_W];
    assign rem       = {1'b0, p_reg} - mul_q[PROD_W:0];
    assign pulse_sum = PSUM_W'(q_reg) + MIN_OP;

    // operand selection for the shared multiplier
    always_comb
    begin
        mul_req.en = 1'b1;
        mul_req.a  = '0;
        mul_req.b  = '0;
        case (state_reg)
            ST_PROP:
            begin
                mul_req.a = $signed({1'b0, kp_reg});
                mul_req.b = MUL_B_W'(err_reg);
            end
            ST_DERIV:
            begin
                mul_req.a = $signed({1'b0, kd_reg});
                mul_req.b = MUL_B_W'(diff_reg);
            end
            ST_SPAN:
            begin
                mul_req.a = SPAN_OP;
                mul_req.b = $signed(MUL_B_W'(thr_reg));
            end
            ST_RECIP:
            begin
                mul_req.a = RECIP_OP;
                mul_req.b = $signed(MUL_B_W'(mul_q[PROD_W-1:0]));
            end
            ST_QMUL:
            begin
                mul_req.a = DIV_OP;
                mul_req.b = $signed(MUL_B_W'(q_est));
            end
            default:
            begin
                mul_req.en = 1'b0;
            end
        endcase
    end

    pdat_mul u_mul (
        .clk     (clk),
        .rst_n   (rst_n),
        .req     (mul_req),
        .product (mul_q)
    );

    // sequencer, configuration and registered outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            target_reg       <= '0;
            kp_reg           <= GAIN_W'(256);
            kd_reg           <= '0;
            base_closed_reg  <= '0;
            limit_closed_reg <= THR_TOP;
            base_open_reg    <= '0;
            limit_open_reg   <= THR_TOP;
            prev_err_reg     <= '0;
            err_reg          <= '0;
            diff_reg         <= '0;
            open_reg         <= 1'b0;
            acc_reg          <= '0;
            thr_reg          <= '0;
            p_reg            <= '0;
            q_reg            <= '0;
            m_valid_reg      <= 1'b0;
            out_thr_reg      <= '0;
            out_pulse_reg    <= '0;
        end
        else
        begin
            // register writes
            if (cfg_wr_en)
            begin
                case (cfg_index)
                    CFG_TARGET:       target_reg       <= cfg_data[ALT_W-1:0];
                    CFG_PROP_GAIN:    kp_reg           <= cfg_data;
                    CFG_DERIV_GAIN:   kd_reg           <= cfg_data;
                    CFG_BASE_CLOSED:  base_closed_reg  <= cfg_data[THR_W-1:0];
                    CFG_LIMIT_CLOSED: limit_closed_reg <= cfg_data[THR_W-1:0];
                    CFG_BASE_OPEN:    base_open_reg    <= cfg_data[THR_W-1:0];
                    CFG_LIMIT_OPEN:   limit_open_reg   <= cfg_data[THR_W-1:0];
                    default:          ;
                endcase
            end

            // result taken downstream, the finishing step loads the next one itself
            if (m_axis_tready && (state_reg != ST_DONE))
            begin
                m_valid_reg <= 1'b0;
            end

            case (state_reg)
                ST_IDLE:
                begin
                    if (s_xfer)
                    begin
                        err_reg      <= err_now;
                        diff_reg     <= diff_now;
                        prev_err_reg <= err_now;
                        open_reg     <= s_axis_tuser[0];
                        state_reg    <= ST_PROP;
                    end
                end
                ST_PROP:
                begin
                    state_reg <= ST_DERIV;
                end
                ST_DERIV:
                begin
                    acc_reg   <= $signed({{(ACC_W-THR_W-FRAC_W){1'b0}}, base_sel, {FRAC_W{1'b0}}})
                                 + mul_q[ACC_W-1:0];
                    state_reg <= ST_SUM;
                end
                ST_SUM:
                begin
                    acc_reg   <= acc_reg + mul_q[ACC_W-1:0];
                    state_reg <= ST_CLAMP;
                end
                ST_CLAMP:
                begin
                    thr_reg   <= thr_next;
                    state_reg <= ST_SPAN;
                end
                ST_SPAN:
                begin
                    state_reg <= ST_RECIP;
                end
                ST_RECIP:
                begin
                    p_reg     <= mul_q[PROD_W-1:0];
                    state_reg <= ST_QMUL;
                end
                ST_QMUL:
                begin
                    q_reg     <= q_est;
                    state_reg <= ST_FIX;
                end
                ST_FIX:
                begin
                    // estimate is at most one short
                    if (rem >= (PROD_W+1)'(THR_MAX))
                    begin
                        q_reg <= q_reg + 1'b1;
                    end
                    state_reg <= ST_DONE;
                end
                ST_DONE:
                begin
                    if (!m_valid_reg || m_axis_tready)
                    begin
                        out_thr_reg   <= thr_reg;
                        out_pulse_reg <= pulse_sum[PULSE_W-1:0];
                        m_valid_reg   <= 1'b1;
                        state_reg     <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = {{(24-THR_W-PULSE_W){1'b0}}, out_pulse_reg, out_thr_reg};

    // busy straight after taking an item
    a_busy_after_take: assert property (@(posedge clk) disable iff (!rst_n)
        s_xfer |=> !s_axis_tready)
        else $error("sequencer took a second item while busy");

    // throttle never above full scale
    a_thr_bound: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> (m_axis_tdata[THR_W-1:0] <= THR_TOP))
        else $error("throttle above full scale");

    // a new result only comes from the finishing step
    a_load_from_done: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_axis_tvalid) |-> $past(state_reg == ST_DONE))
        else $error("result loaded outside the finishing step");

    // corrected quotient leaves a remainder below the divisor
    a_quot_exact: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_FIX) |-> (rem < (PROD_W+1)'(2 * THR_MAX)))
        else $error("reciprocal estimate more than one short");

endmodule
